// ===== rtl/ogre_pkg.sv =====
`default_nettype none
package ogre_pkg;

  localparam int MAP_SIDE = 512;
  localparam int DEPTH    = MAP_SIDE * MAP_SIDE;
  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = $clog2(MAP_SIDE);
  localparam int NW       = 20;
  localparam int PW       = 32;
  localparam int SUM_W    = 48;
  localparam int CNT_W    = 24;
  localparam int SCALE_SH = 10;
  localparam int NUM_W    = SUM_W + SCALE_SH;
  localparam int DEN_W    = CNT_W;
  localparam int WFULL    = 256;

  localparam logic signed [NW-1:0] SIDE_S = NW'(MAP_SIDE);
  localparam logic signed [NW-1:0] TOP_S  = NW'(MAP_SIDE - 1);
  localparam logic [30:0] SCORE_NONE = 31'd2000000000;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_RAY   = 2'd1,
    OP_SCORE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic {
    CFG_OBSTACLE = 1'b0,
    CFG_FREE     = 1'b1
  } cfg_e;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_RAY, S_CLIP, S_CLIP_GO, S_CLIP_WAIT, S_SETUP, S_INC_GO,
    S_INC_WAIT, S_PIX, S_MUL, S_WR, S_SC, S_SC_ADD, S_SC_END, S_SC_GO,
    S_SC_WAIT, S_RD, S_RD_W, S_FIN
  } state_e;

  typedef struct packed {
    op_e                op;
    logic signed [15:0] robot_x;
    logic signed [15:0] robot_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic signed [15:0] peak_x;
    logic signed [15:0] peak_y;
    logic [15:0]        target_value;
    logic [8:0]         blend_weight;
    logic               is_last;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [30:0] score;
    logic [15:0] cell_value;
    logic        out_of_map;
  } rsp_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] q;
    logic [DEN_W-1:0] rem;
  } div_rsp_t;

  function automatic logic in_map(input logic signed [NW-1:0] x,
                                  input logic signed [NW-1:0] y);
    return (x >= 0) && (x < SIDE_S) && (y >= 0) && (y < SIDE_S);
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic signed [NW-1:0] x,
                                              input logic signed [NW-1:0] y);
    return AW'(y[CW-1:0]) * AW'(MAP_SIDE) + AW'(x[CW-1:0]);
  endfunction

  function automatic logic signed [NW-1:0] abs_s(input logic signed [NW-1:0] v);
    return v[NW-1] ? -v : v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ogre_if.sv =====
`default_nettype none
interface ogre_req_if;
  import ogre_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ogre_rsp_if;
  import ogre_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/ogre_ram.sv =====
`default_nettype none
module ogre_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [W-1:0]       rdata_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ogre_div.sv =====
`default_nettype none
module ogre_div
  import ogre_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int IW = $clog2(NUM_W);

  logic             busy_q, done_q;
  logic [IW-1:0]    cnt_q;
  logic [NUM_W-1:0] num_q, q_q;
  logic [DEN_W-1:0] den_q, rem_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == IW'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
      q_q   <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      q_q   <= {q_q[NUM_W-2:0], fits};
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = q_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

// ===== rtl/occupancy_grid_ray_engine.sv =====
`default_nettype none
// Occupancy grid ray engine: one request at a time, one response register on
// the output. Timing is set by the simple dual-port grid memory and the one
// bit-per-cycle divider. Clear sweeps the whole grid, one cell a cycle. A ray
// takes up to four clipping divisions and one profile division, then reads,
// multiplies and writes back each cell walked. The last point of a scan with
// any hits also runs a division for the score. The grid holds garbage after
// reset until the first clear.
module occupancy_grid_ray_engine
  import ogre_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  ogre_req_if.sink         req_i,
  ogre_rsp_if.source       rsp_o
);

  state_e state_q, state_d;

  logic [15:0] obs_q, free_q;
  req_t        req_q;
  rsp_t        res_q, out_q;
  logic        out_v_q;

  logic [AW-1:0] clr_q;
  logic [1:0]    clip_k_q;
  logic signed [NW-1:0] xc_q, yc_q, den_q;
  logic signed [2*NW-1:0] prod_q;

  logic signed [NW-1:0] dx_q, dxc_q, dv_q, err_q, horiz_q, diago_q, ev_q;
  logic signed [NW-1:0] inc_q, incerr_q, cx_q, cy_q, i_q;
  logic signed [PW-1:0] pix_q;
  logic                 majx_q, stx_neg_q, sty_neg_q, sinc_pos_q, neg_q;
  logic                 cell_in_q;
  logic [AW-1:0]        addr_q;
  logic [24:0]          p1_q;
  logic signed [41:0]   p2_q;

  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] cnt_q;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata, mem_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // request coordinates
  logic signed [NW-1:0] x1, y1, x2, y2, xp, yp;
  assign x1 = NW'(req_q.robot_x);
  assign y1 = NW'(req_q.robot_y);
  assign x2 = NW'(req_q.end_x);
  assign y2 = NW'(req_q.end_y);
  assign xp = NW'(req_q.peak_x);
  assign yp = NW'(req_q.peak_y);

  logic signed [NW-1:0] tdiff;
  assign tdiff = $signed({{(NW-16){1'b0}}, req_q.target_value})
               - $signed({{(NW-16){1'b0}}, free_q});

  logic [16:0] mid_sum;
  assign mid_sum = {1'b0, obs_q} + {1'b0, free_q};

  // clipping stage
  logic                 clip_cond;
  logic signed [NW-1:0] clip_a, clip_b, clip_den;
  always_comb begin
    clip_cond = 1'b0;
    clip_a    = '0;
    clip_b    = '0;
    clip_den  = '0;
    case (clip_k_q)
      2'd0: begin
        clip_cond = xc_q < 0;
        clip_a    = yc_q - y1;
        clip_b    = -xc_q;
        clip_den  = xc_q - x1;
      end
      2'd1: begin
        clip_cond = xc_q > TOP_S;
        clip_a    = yc_q - y1;
        clip_b    = TOP_S - xc_q;
        clip_den  = xc_q - x1;
      end
      2'd2: begin
        clip_cond = yc_q < 0;
        clip_a    = x1 - xc_q;
        clip_b    = -yc_q;
        clip_den  = y1 - yc_q;
      end
      default: begin
        clip_cond = yc_q > TOP_S;
        clip_a    = x1 - xc_q;
        clip_b    = TOP_S - yc_q;
        clip_den  = y1 - yc_q;
      end
    endcase
  end

  // signed quotient and remainder
  logic signed [NW-1:0] q_s, rem_s;
  assign q_s   = neg_q ? -NW'(div_rsp.q) : NW'(div_rsp.q);
  assign rem_s = (tdiff < 0) ? -NW'(div_rsp.rem) : NW'(div_rsp.rem);

  logic signed [2*NW-1:0] prod_abs;
  assign prod_abs = prod_q[2*NW-1] ? -prod_q : prod_q;

  // ray setup
  logic signed [NW-1:0] adx, ady, adxc, adyc, dvx, dvy, dv_raw, dv_s, dyc_s, dxc_s;
  logic                 majx;
  always_comb begin
    adx    = abs_s(x2 - x1);
    ady    = abs_s(y2 - y1);
    adxc   = abs_s(xc_q - x1);
    adyc   = abs_s(yc_q - y1);
    dvx    = abs_s(xp - x2);
    dvy    = abs_s(yp - y2);
    majx   = adx > ady;
    dv_raw = majx ? dvx : dvy;
    dv_s   = (dv_raw == 0) ? NW'(1) : dv_raw;
    dxc_s  = majx ? adxc : adyc;
    dyc_s  = majx ? adyc : adxc;
  end

  // profile step
  logic signed [PW-1:0] pix_nx;
  logic signed [NW-1:0] ev_nx, thr1, thr2;
  always_comb begin
    pix_nx = pix_q;
    ev_nx  = ev_q;
    thr1   = dx_q - (dv_q <<< 1);
    thr2   = dx_q - dv_q;
    if (i_q > thr1) begin
      if (i_q <= thr2) begin
        pix_nx = pix_q + PW'(inc_q);
        ev_nx  = ev_q + incerr_q;
        if (ev_nx > dv_q) begin
          pix_nx = sinc_pos_q ? pix_nx + 1 : pix_nx - 1;
          ev_nx  = ev_nx - dv_q;
        end
      end else begin
        pix_nx = pix_q - PW'(inc_q);
        ev_nx  = ev_q - incerr_q;
        if (ev_nx < 0) begin
          pix_nx = sinc_pos_q ? pix_nx - 1 : pix_nx + 1;
          ev_nx  = ev_nx + dv_q;
        end
      end
    end
  end

  // blend
  logic [8:0]         w_sat, w_inv;
  logic signed [42:0] blend_sum, blend_sh;
  logic [15:0]        blend_val;
  always_comb begin
    w_sat     = (req_q.blend_weight > 9'(WFULL)) ? 9'(WFULL) : req_q.blend_weight;
    w_inv     = 9'(WFULL) - w_sat;
    blend_sum = 43'(p2_q) + 43'($signed({1'b0, p1_q}));
    blend_sh  = blend_sum >>> 8;
    if (blend_sum < 0) begin
      blend_val = '0;
    end else if (blend_sh > 43'sd65535) begin
      blend_val = 16'hFFFF;
    end else begin
      blend_val = blend_sh[15:0];
    end
  end

  logic pt_in, score_hit;
  assign pt_in     = in_map(x2, y2);
  assign score_hit = (req_q.target_value != free_q) && pt_in && (cnt_q != CNT_MAX);

  // control
  always_comb begin
    state_d       = state_q;
    mem_we        = 1'b0;
    mem_waddr     = addr_q;
    mem_wdata     = blend_val;
    mem_re        = 1'b0;
    mem_raddr     = cell_addr(cx_q, cy_q);
    div_req.start = 1'b0;
    div_req.num   = NUM_W'($unsigned(prod_abs));
    div_req.den   = DEN_W'($unsigned(abs_s(den_q)));
    req_i.ready   = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          case (req_i.payload.op)
            OP_CLEAR: state_d = S_CLR;
            OP_RAY:   state_d = S_RAY;
            OP_SCORE: state_d = S_SC;
            default:  state_d = S_RD;
          endcase
        end
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = mid_sum[16:1];
        if (clr_q == AW'(DEPTH - 1)) state_d = S_FIN;
      end
      S_RAY: state_d = in_map(x1, y1) ? S_CLIP : S_FIN;
      S_CLIP: begin
        if (!clip_cond) begin
          if (clip_k_q == 2'd3) state_d = S_SETUP;
        end else if (clip_den == 0) begin
          state_d = S_FIN;
        end else begin
          state_d = S_CLIP_GO;
        end
      end
      S_CLIP_GO: begin
        div_req.start = 1'b1;
        state_d       = S_CLIP_WAIT;
      end
      S_CLIP_WAIT: begin
        if (div_rsp.done) state_d = (clip_k_q == 2'd3) ? S_SETUP : S_CLIP;
      end
      S_SETUP: state_d = S_INC_GO;
      S_INC_GO: begin
        div_req.start = 1'b1;
        div_req.num   = NUM_W'($unsigned(abs_s(tdiff)));
        div_req.den   = DEN_W'($unsigned(dv_q));
        state_d       = S_INC_WAIT;
      end
      S_INC_WAIT: if (div_rsp.done) state_d = S_PIX;
      S_PIX: begin
        mem_re  = in_map(cx_q, cy_q);
        state_d = S_MUL;
      end
      S_MUL: state_d = S_WR;
      S_WR: begin
        mem_we  = cell_in_q;
        state_d = (i_q == dxc_q) ? S_FIN : S_PIX;
      end
      S_SC: begin
        mem_re    = score_hit;
        mem_raddr = cell_addr(x2, y2);
        state_d   = score_hit ? S_SC_ADD : S_SC_END;
      end
      S_SC_ADD: state_d = S_SC_END;
      S_SC_END: begin
        if (!req_q.is_last) state_d = S_IDLE;
        else if (cnt_q == '0) state_d = S_FIN;
        else state_d = S_SC_GO;
      end
      S_SC_GO: begin
        div_req.start = 1'b1;
        div_req.num   = {sum_q, SCALE_SH'(0)};
        div_req.den   = cnt_q;
        state_d       = S_SC_WAIT;
      end
      S_SC_WAIT: if (div_rsp.done) state_d = S_FIN;
      S_RD: begin
        mem_re    = pt_in;
        mem_raddr = cell_addr(x2, y2);
        state_d   = pt_in ? S_RD_W : S_FIN;
      end
      S_RD_W: state_d = S_FIN;
      S_FIN: if (!out_v_q || rsp_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obs_q  <= '0;
      free_q <= 16'd65500;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_OBSTACLE: obs_q <= cfg_data_i;
        CFG_FREE:     free_q <= cfg_data_i;
        default:      obs_q <= obs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (state_q == S_FIN && (!out_v_q || rsp_o.ready)) begin
      out_v_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (state_q == S_SC_ADD) begin
      sum_q <= sum_q + SUM_W'(mem_rdata);
      cnt_q <= cnt_q + 1'b1;
    end else if (state_q == S_SC_GO) begin
      sum_q <= '0;
      cnt_q <= '0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        req_q <= req_i.payload;
        res_q <= rsp_t'({req_i.payload.op, 48'd0});
        clr_q <= '0;
      end
      S_CLR: clr_q <= clr_q + 1'b1;
      S_RAY: begin
        xc_q     <= x2;
        yc_q     <= y2;
        clip_k_q <= 2'd0;
        if (!in_map(x1, y1)) res_q.out_of_map <= 1'b1;
      end
      S_CLIP: begin
        prod_q <= clip_a * clip_b;
        den_q  <= clip_den;
        neg_q  <= clip_a[NW-1] ^ clip_b[NW-1] ^ clip_den[NW-1];
        if (!clip_cond) clip_k_q <= clip_k_q + 1'b1;
      end
      S_CLIP_WAIT: begin
        if (div_rsp.done) begin
          clip_k_q <= clip_k_q + 1'b1;
          case (clip_k_q)
            2'd0: begin yc_q <= yc_q + q_s; xc_q <= '0; end
            2'd1: begin yc_q <= yc_q + q_s; xc_q <= TOP_S; end
            2'd2: begin xc_q <= xc_q + q_s; yc_q <= '0; end
            default: begin xc_q <= xc_q + q_s; yc_q <= TOP_S; end
          endcase
        end
      end
      S_SETUP: begin
        majx_q     <= majx;
        dx_q       <= majx ? adx : ady;
        dxc_q      <= dxc_s;
        dv_q       <= dv_s;
        err_q      <= (dyc_s <<< 1) - dxc_s;
        horiz_q    <= dyc_s <<< 1;
        diago_q    <= (dyc_s - dxc_s) <<< 1;
        ev_q       <= dv_s >>> 1;
        pix_q      <= PW'(free_q);
        cx_q       <= x1;
        cy_q       <= y1;
        i_q        <= '0;
        stx_neg_q  <= !(x2 > x1);
        sty_neg_q  <= !(y2 > y1);
        sinc_pos_q <= req_q.target_value > free_q;
        neg_q      <= tdiff < 0;
      end
      S_INC_WAIT: begin
        inc_q    <= q_s;
        incerr_q <= rem_s;
      end
      S_PIX: begin
        pix_q     <= pix_nx;
        ev_q      <= ev_nx;
        cell_in_q <= in_map(cx_q, cy_q);
        addr_q    <= cell_addr(cx_q, cy_q);
      end
      S_MUL: begin
        p1_q <= w_inv * mem_rdata;
        p2_q <= $signed({1'b0, w_sat}) * pix_q;
      end
      S_WR: begin
        i_q <= i_q + 1'b1;
        if (majx_q) begin
          cx_q <= stx_neg_q ? cx_q - NW'(1) : cx_q + NW'(1);
          if (err_q > 0) cy_q <= sty_neg_q ? cy_q - NW'(1) : cy_q + NW'(1);
        end else begin
          cy_q <= sty_neg_q ? cy_q - NW'(1) : cy_q + NW'(1);
          if (err_q > 0) cx_q <= stx_neg_q ? cx_q - NW'(1) : cx_q + NW'(1);
        end
        err_q <= (err_q > 0) ? err_q + diago_q : err_q + horiz_q;
      end
      S_SC_END: if (cnt_q == '0) res_q.score <= SCORE_NONE;
      S_SC_WAIT: if (div_rsp.done) res_q.score <= div_rsp.q[30:0];
      S_RD: if (!pt_in) res_q.out_of_map <= 1'b1;
      S_RD_W: res_q.cell_value <= mem_rdata;
      S_FIN: if (!out_v_q || rsp_o.ready) out_q <= res_q;
      default: clr_q <= clr_q;
    endcase
  end

  assign rsp_o.valid   = out_v_q;
  assign rsp_o.payload = out_q;

  ogre_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ogre_ram #(
    .W     (16),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
`default_nettype wire

// ===== rtl/ogre_chk.sv =====
`default_nettype none
module ogre_chk
  import ogre_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp_payload
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> $stable(rsp_payload))
    else $error("response changed while stalled");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one still running");

  a_score_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_payload.result_kind != OP_SCORE |-> rsp_payload.score == '0)
    else $error("score set outside score response");

  a_clear_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (rsp_payload.result_kind == OP_CLEAR ||
                  rsp_payload.result_kind == OP_SCORE)
    |-> !rsp_payload.out_of_map && rsp_payload.cell_value == '0)
    else $error("cell fields set in clear or score response");

endmodule

bind occupancy_grid_ray_engine ogre_chk u_ogre_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid   (req_i.valid),
  .req_ready   (req_i.ready),
  .rsp_valid   (rsp_o.valid),
  .rsp_ready   (rsp_o.ready),
  .rsp_payload (rsp_o.payload)
);
`default_nettype wire

// ===== bench/occupancy_grid_ray_engine_tb.sv =====
module occupancy_grid_ray_engine_tb;
  import ogre_pkg::*;

  localparam int LIMIT_CYCLES = 20_000_000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int TOP          = MAP_SIDE - 1;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;

  ogre_req_if req_if ();
  ogre_rsp_if rsp_if ();

  occupancy_grid_ray_engine u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // grid mirror and scan accumulators
  logic [15:0] grid_mem [0:DEPTH-1];
  longint      scan_sum;
  longint      scan_cnt;
  longint      obst_lvl;
  longint      free_lvl;
  rsp_t        expected_rsp [$];

  int  send_idle_pct;
  int  recv_stall_pct;
  int  fail_cnt;
  int  hold_cnt;
  logic hold_req;
  longint cycle_cnt;

  function automatic bit on_grid(longint x, longint y);
    return x >= 0 && x < MAP_SIDE && y >= 0 && y < MAP_SIDE;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  task automatic trace_ray(longint x1, longint y1, longint x2, longint y2,
                           longint xp, longint yp, longint value, longint w);
    longint xc, yc, dx, dy, dxc, dyc, stx, sty, dv, inc, incerr, sinc, ev, pix;
    longint mjx, mjy, mnx, mny, err, horiz, diago, cx, cy, t;
    xc = x2;
    yc = y2;
    if (xc < 0) begin
      if (xc == x1) return;
      yc += (yc - y1) * (-xc) / (xc - x1);
      xc = 0;
    end
    if (xc > TOP) begin
      if (xc == x1) return;
      yc += (yc - y1) * (TOP - xc) / (xc - x1);
      xc = TOP;
    end
    if (yc < 0) begin
      if (yc == y1) return;
      xc += (x1 - xc) * (-yc) / (y1 - yc);
      yc = 0;
    end
    if (yc > TOP) begin
      if (yc == y1) return;
      xc += (x1 - xc) * (TOP - yc) / (y1 - yc);
      yc = TOP;
    end
    dx = mag(x2 - x1);
    dy = mag(y2 - y1);
    dxc = mag(xc - x1);
    dyc = mag(yc - y1);
    stx = (x2 > x1) ? 1 : -1;
    sty = (y2 > y1) ? 1 : -1;
    sinc = (value > free_lvl) ? 1 : -1;
    if (dx > dy) begin
      mjx = stx; mjy = 0; mnx = 0; mny = sty;
      dv = mag(xp - x2);
    end else begin
      t = dx; dx = dy; dy = t;
      t = dxc; dxc = dyc; dyc = t;
      mjx = 0; mjy = sty; mnx = stx; mny = 0;
      dv = mag(yp - y2);
    end
    if (dv == 0) dv = 1;
    err = 2 * dyc - dxc;
    horiz = 2 * dyc;
    diago = 2 * (dyc - dxc);
    ev = dv / 2;
    inc = (value - free_lvl) / dv;
    incerr = value - free_lvl - dv * inc;
    pix = free_lvl;
    cx = x1;
    cy = y1;
    for (longint i = 0; i <= dxc; i++) begin
      if (i > dx - 2 * dv) begin
        if (i <= dx - dv) begin
          pix += inc;
          ev += incerr;
          if (ev > dv) begin pix += sinc; ev -= dv; end
        end else begin
          pix -= inc;
          ev -= incerr;
          if (ev < 0) begin pix -= sinc; ev += dv; end
        end
      end
      if (on_grid(cx, cy)) begin
        t = (256 - w) * longint'(grid_mem[cy * MAP_SIDE + cx]) + w * pix;
        t = (t < 0) ? 0 : (t >>> 8);
        if (t > 65535) t = 65535;
        grid_mem[cy * MAP_SIDE + cx] = t[15:0];
      end
      cx += mjx;
      cy += mjy;
      if (err > 0) begin
        cx += mnx;
        cy += mny;
        err += diago;
      end else begin
        err += horiz;
      end
    end
  endtask

  task automatic apply_request(input req_t r);
    rsp_t   e;
    longint ex, ey, w, q;
    ex = longint'(r.end_x);
    ey = longint'(r.end_y);
    w = (r.blend_weight > 256) ? 256 : r.blend_weight;
    e = '0;
    e.result_kind = r.op;
    case (r.op)
      OP_CLEAR: begin
        q = (obst_lvl + free_lvl) / 2;
        for (int k = 0; k < DEPTH; k++) grid_mem[k] = q[15:0];
      end
      OP_RAY: begin
        if (!on_grid(longint'(r.robot_x), longint'(r.robot_y))) e.out_of_map = 1'b1;
        else trace_ray(longint'(r.robot_x), longint'(r.robot_y), ex, ey,
                       longint'(r.peak_x), longint'(r.peak_y), r.target_value, w);
      end
      OP_SCORE: begin
        if (r.target_value != free_lvl && on_grid(ex, ey) && scan_cnt < CNT_MAX) begin
          scan_sum = (scan_sum + grid_mem[ey * MAP_SIDE + ex]) & 64'hFFFF_FFFF_FFFF;
          scan_cnt++;
        end
        if (!r.is_last) return;
        if (scan_cnt != 0) begin
          q = (scan_sum * 1024) / scan_cnt;
          e.score = q[30:0];
        end else begin
          e.score = SCORE_NONE;
        end
        scan_sum = 0;
        scan_cnt = 0;
      end
      default: begin
        if (on_grid(ex, ey)) e.cell_value = grid_mem[ey * MAP_SIDE + ex];
        else e.out_of_map = 1'b1;
      end
    endcase
    expected_rsp.push_back(e);
  endtask

  task automatic send_request(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (!req_if.ready);
    apply_request(r);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp.size() == 0) begin
        $error("unexpected response kind %0d", rsp_if.payload.result_kind);
        fail_cnt++;
      end else begin
        rsp_t e;
        e = expected_rsp.pop_front();
        if (rsp_if.payload.result_kind !== e.result_kind) begin
          $error("result_kind exp %0d got %0d", e.result_kind, rsp_if.payload.result_kind);
          fail_cnt++;
        end
        if (rsp_if.payload.score !== e.score) begin
          $error("score exp %0d got %0d", e.score, rsp_if.payload.score);
          fail_cnt++;
        end
        if (rsp_if.payload.cell_value !== e.cell_value) begin
          $error("cell_value exp %0d got %0d", e.cell_value, rsp_if.payload.cell_value);
          fail_cnt++;
        end
        if (rsp_if.payload.out_of_map !== e.out_of_map) begin
          $error("out_of_map exp %0d got %0d", e.out_of_map, rsp_if.payload.out_of_map);
          fail_cnt++;
        end
      end
    end
  end

  // receiver stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_cnt <= HOLD_CYCLES;
      hold_req <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
    rsp_if.ready <= (hold_cnt == 0 && !hold_req) && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("[occupancy_grid_ray_engine] ERROR");
      $finish;
    end
  end

  function automatic req_t blank_req(op_e op);
    req_t r;
    r = '0;
    r.op = op;
    r.blend_weight = 9'd128;
    return r;
  endfunction

  function automatic req_t make_ray(int rx, int ry, int ex, int ey, int px, int py,
                                    int tv, int w);
    req_t r;
    r = blank_req(OP_RAY);
    r.robot_x = rx[15:0];
    r.robot_y = ry[15:0];
    r.end_x = ex[15:0];
    r.end_y = ey[15:0];
    r.peak_x = px[15:0];
    r.peak_y = py[15:0];
    r.target_value = tv[15:0];
    r.blend_weight = w[8:0];
    return r;
  endfunction

  function automatic req_t make_point(op_e op, int x, int y, int tv, bit last);
    req_t r;
    r = blank_req(op);
    r.end_x = x[15:0];
    r.end_y = y[15:0];
    r.target_value = tv[15:0];
    r.is_last = last;
    r.robot_x = $urandom();
    r.robot_y = $urandom();
    r.peak_x = $urandom();
    r.peak_y = $urandom();
    r.blend_weight = $urandom();
    return r;
  endfunction

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_level(cfg_e idx, int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[15:0];
    @(posedge clk_i);
    if (idx == CFG_OBSTACLE) obst_lvl = value[15:0];
    else free_lvl = value[15:0];
  endtask

  task automatic set_levels(int obstacle, int free);
    wait_idle();
    write_level(CFG_OBSTACLE, obstacle);
    write_level(CFG_FREE, free);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset();
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_levels(0, 65500);
  endtask

  task automatic test_clear();
    send_request(blank_req(OP_CLEAR));
    wait_idle();
  endtask

  task automatic test_directed();
    send_request(make_point(OP_READ, 0, 0, 0, 0));
    send_request(make_point(OP_READ, TOP, TOP, 0, 0));
    send_request(make_point(OP_READ, MAP_SIDE, 0, 0, 0));
    send_request(make_point(OP_READ, -1, 5, 0, 0));
    send_request(make_point(OP_READ, -32768, 32767, 0, 0));
    // start off the map
    send_request(make_ray(-32768, -32768, 32767, 32767, 0, 0, 65535, 256));
    send_request(make_ray(TOP, MAP_SIDE, 10, 10, 10, 10, 0, 256));
    // clipped on the x borders and the low y border
    send_request(make_ray(100, 100, 32767, 100, 700, 100, 0, 200));
    send_request(make_ray(300, 200, -32768, 210, -32760, 210, 65535, 511));
    send_request(make_ray(50, 400, 60, -32768, 60, -32767, 1000, 64));
    send_request(make_ray(256, 256, 32767, -32768, 32767, -32768, 0, 256));
    // zero length, zero width, weight extremes, no hit
    send_request(make_ray(10, 10, 10, 10, 10, 10, 0, 256));
    send_request(make_ray(20, 20, 30, 25, 30, 25, 0, 0));
    send_request(make_ray(20, 30, 30, 35, 29, 35, 65535, 511));
    send_request(make_ray(40, 40, 45, 52, 45, 50, 65500, 256));
    send_request(make_point(OP_READ, 25, 22, 0, 0));
    send_request(make_point(OP_READ, 200, 100, 0, 0));
    // empty scan, then a scored one
    send_request(make_point(OP_SCORE, -5, 3, 0, 0));
    send_request(make_point(OP_SCORE, 25, 22, 65500, 0));
    send_request(make_point(OP_SCORE, 600, 600, 1, 1));
    send_request(make_point(OP_SCORE, 25, 22, 0, 0));
    send_request(make_point(OP_SCORE, 200, 100, 65535, 0));
    send_request(make_point(OP_SCORE, 0, 0, 7, 1));
  endtask

  function automatic int rand_coord();
    if ($urandom_range(9) == 0) return $urandom_range(65535) - 32768;
    return $urandom_range(TOP);
  endfunction

  function automatic int rand_level();
    case ($urandom_range(5))
      0: return free_lvl;
      1: return obst_lvl;
      default: return $urandom_range(65535);
    endcase
  endfunction

  task automatic send_random_ray();
    int rx, ry, ex, ey, px, py, w;
    rx = rand_coord();
    ry = rand_coord();
    if ($urandom_range(99) < 6) begin
      ex = $urandom_range(65535) - 32768;
      ey = $urandom_range(65535) - 32768;
    end else begin
      ex = rx + $urandom_range(24) - 12;
      ey = ry + $urandom_range(24) - 12;
    end
    px = ($urandom_range(3) == 0) ? ex : ex + $urandom_range(8) - 4;
    py = ($urandom_range(3) == 0) ? ey : ey + $urandom_range(8) - 4;
    w = ($urandom_range(19) == 0) ? $urandom_range(511, 257) : $urandom_range(256);
    send_request(make_ray(rx, ry, ex, ey, px, py, rand_level(), w));
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int n_items);
    int sent, k;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7: begin
          send_random_ray();
          sent++;
        end
        8, 9, 10, 11, 12, 13, 14: begin
          k = $urandom_range(8);
          for (int i = 0; i <= k; i++) begin
            send_request(make_point(OP_SCORE, rand_coord(), rand_coord(), rand_level(),
                                    (i == k) || ($urandom_range(19) == 0)));
          end
          sent += k + 1;
        end
        default: begin
          send_request(make_point(OP_READ, rand_coord(), rand_coord(), 0, 0));
          sent++;
        end
      endcase
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 0) send_random_ray();
      else send_request(make_point(OP_READ, rand_coord(), rand_coord(), 0, 0));
    end
    wait_idle();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_OBSTACLE;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    rsp_if.ready = 1'b0;
    hold_req = 1'b0;
    hold_cnt = 0;
    cycle_cnt = 0;
    fail_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    scan_sum = 0;
    scan_cnt = 0;
    obst_lvl = 0;
    free_lvl = 65500;

    test_reset();
    test_clear();
    test_directed();
    wait_idle();
    run_phase(0, 0, 330);
    set_levels(65535, 0);
    run_phase(54, 0, 330);
    set_levels(1000, 60000);
    test_clear();
    run_phase(0, 54, 330);
    test_backpressure();
    set_levels(65535, 65535);
    run_phase(38, 38, 330);
    set_levels(0, 0);
    run_phase(0, 0, 20);
    wait_idle();

    if (fail_cnt == 0) begin
      $display("[occupancy_grid_ray_engine] OK");
    end else begin
      $display("[occupancy_grid_ray_engine] ERROR");
    end
    $finish;
  end

endmodule
